// ===== src/modular_division_fermat_assert.svh =====
// Assertion macros for the modular division block.
// Used by the top level only; needs clk and rst in the enclosing scope.
`ifndef MODULAR_DIVISION_FERMAT_ASSERT_SVH
`define MODULAR_DIVISION_FERMAT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define MDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mdf_pkg.sv =====
// Constants shared by the modular division block.
// No dependencies.
package mdf_pkg;
  localparam logic [29:0] MODP    = 30'd998244353;
  localparam logic [31:0] MODP_X2 = 32'd1996488706;
  localparam logic [29:0] EXP     = 30'd998244351;
  localparam int          STEPS   = 30;
  localparam int          MUL_LAT = 4;
  // Barrett factor floor(2^60 / MODP), 31 bits.
  localparam logic [30:0] MU      = 31'((64'd1 << 60) / 64'd998244353);
endpackage

// ===== src/modular_division_fermat.sv =====
// Modular division p / q in GF(998244353) as p * q^(MODP-2), square-and-multiply.
// Pipeline: input reduce stage, 30 exponent steps, output register.
// Throughput: one beat per cycle while the skid entry is empty; each step's 4-stage Barrett multiplier sets the depth.
// A two-entry output buffer lets the pipeline run while a result waits.
// Reset (rst, synchronous, active high) clears all valid bits; no data state.
`include "modular_division_fermat_assert.svh"
module modular_division_fermat (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [29:0] dividend, [59:30] divisor, [63:60] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [29:0] quotient, [31:30] zero
);
  localparam int STEPS = mdf_pkg::STEPS;
  localparam int LAT   = mdf_pkg::MUL_LAT;

  logic        en;
  logic [29:0] acc_s  [STEPS+1];
  logic [29:0] base_s [STEPS];
  logic        vld_s  [STEPS+1];
  logic [29:0] dvd_in, dvs_in;

  logic        out_valid;
  logic [29:0] out_data;
  logic        skid_valid;
  logic [29:0] skid_data;

  // Advance the whole pipe unless the skid entry is occupied.
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  assign dvd_in = s_axis_tdata[29:0];
  assign dvs_in = s_axis_tdata[59:30];

  // Input stage: fold operands into range (2^30 < 2*MODP, so one subtract).
  always_ff @(posedge clk) begin
    if (en) begin
      acc_s[0]  <= (dvd_in >= mdf_pkg::MODP) ? dvd_in - mdf_pkg::MODP : dvd_in;
      base_s[0] <= (dvs_in >= mdf_pkg::MODP) ? dvs_in - mdf_pkg::MODP : dvs_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (en) begin
      vld_s[0] <= s_axis_tvalid;
    end
  end

  // One step per exponent bit, LSB first.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [LAT-1:0] vsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vsh <= '0;
      end else if (en) begin
        vsh <= {vsh[LAT-2:0], vld_s[i]};
      end
    end
    assign vld_s[i+1] = vsh[LAT-1];

    if (mdf_pkg::EXP[i]) begin : g_mul
      mdf_mulmod u_acc (
        .clk (clk),
        .en  (en),
        .a   (acc_s[i]),
        .b   (base_s[i]),
        .r   (acc_s[i+1])
      );
    end else begin : g_hold
      // Bit is clear: hold the accumulator in step with the multiplier depth.
      logic [29:0] dly [LAT];
      always_ff @(posedge clk) begin
        if (en) begin
          dly[0] <= acc_s[i];
          for (int k = 1; k < LAT; k++) begin
            dly[k] <= dly[k-1];
          end
        end
      end
      assign acc_s[i+1] = dly[LAT-1];
    end

    if (i < STEPS - 1) begin : g_sq
      mdf_mulmod u_sq (
        .clk (clk),
        .en  (en),
        .a   (base_s[i]),
        .b   (base_s[i]),
        .r   (base_s[i+1])
      );
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= vld_s[STEPS];
      end
    end else if (en && vld_s[STEPS]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : acc_s[STEPS];
    end else if (en && vld_s[STEPS]) begin
      skid_data <= acc_s[STEPS];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_data};

  `MDF_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid filled with output empty")
  `MDF_ASSERT_NOW(a_result_range, out_valid, out_data < mdf_pkg::MODP, "quotient not reduced")
  `MDF_ASSERT_NEXT(a_skid_drains, skid_valid && m_axis_tready, !skid_valid, "skid did not drain")
endmodule

// ===== src/mdf_mulmod.sv =====
// Four-stage pipelined a*b mod MODP using Barrett reduction.
// Depends on mdf_pkg.
module mdf_mulmod (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic [29:0] r
);
  logic [59:0] prod1;
  logic [61:0] q2;
  logic [31:0] lo2;
  logic [31:0] lo3;
  logic [31:0] t3;
  logic [31:0] rem;

  assign rem = lo3 - t3;

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= {30'd0, a} * {30'd0, b};
      q2    <= {31'd0, prod1[59:29]} * {31'd0, mdf_pkg::MU};
      lo2   <= prod1[31:0];
      t3    <= {1'b0, q2[61:31]} * {2'b0, mdf_pkg::MODP};
      lo3   <= lo2;
      // Barrett estimate is short by at most two multiples.
      if (rem >= mdf_pkg::MODP_X2) begin
        r <= 30'(rem - mdf_pkg::MODP_X2);
      end else if (rem >= {2'b0, mdf_pkg::MODP}) begin
        r <= 30'(rem - {2'b0, mdf_pkg::MODP});
      end else begin
        r <= rem[29:0];
      end
    end
  end
endmodule

// ===== dv/mdf_quotient_checker.sv =====
// Checker for the modular division block: watches both stream channels,
// predicts each quotient and compares it with the output beats.
// Depends on mdf_pkg for the prime modulus.
`timescale 1ns / 100ps
module mdf_quotient_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          errors,
  output int          pending
);
  localparam int DEPTH = 1024;

  // Expected quotients in arrival order; free-running write and read counts.
  logic [29:0] expected_mem [DEPTH];
  int          wr_count = 0;
  int          rd_count = 0;

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b);
    return (a * b) % 64'(mdf_pkg::MODP);
  endfunction

  // Square-and-multiply over the fixed exponent, lsb first.
  function automatic logic [29:0] divide_mod(logic [29:0] p, logic [29:0] q);
    logic [63:0] acc;
    logic [63:0] base;
    logic [29:0] e;
    acc  = 64'(p) % 64'(mdf_pkg::MODP);
    base = 64'(q) % 64'(mdf_pkg::MODP);
    e    = mdf_pkg::MODP - 30'd2;
    for (int i = 0; i < 30; i++) begin
      if (e[i]) acc = mul_mod(acc, base);
      base = mul_mod(base, base);
    end
    return acc[29:0];
  endfunction

  task automatic report(string what, logic [29:0] got, logic [29:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = wr_count - rd_count;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_mem[wr_count % DEPTH] = divide_mod(s_axis_tdata[29:0],
                                                    s_axis_tdata[59:30]);
        wr_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_count == rd_count) begin
          report("unexpected quotient", m_axis_tdata[29:0], '0);
        end else begin
          if (m_axis_tdata[29:0] !== expected_mem[rd_count % DEPTH])
            report("quotient", m_axis_tdata[29:0], expected_mem[rd_count % DEPTH]);
          rd_count++;
        end
      end
    end
  end
endmodule

// ===== dv/tb_modular_division_fermat.sv =====
// Testbench top for the modular division block: drives operand beats with
// random gaps and output stalls; the checker module predicts and compares.
// Depends on mdf_pkg, modular_division_fermat and mdf_quotient_checker.
`timescale 1ns / 100ps
module tb_modular_division_fermat;
  localparam int LATENCY    = 122;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 530;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [29:0] dividend, [59:30] divisor, [63:60] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;        // [29:0] quotient, [31:30] zero
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  bit          hold_off = 0;       // long receiver stall requested by the sender
  bit          stall_mode = 1;     // random receiver stalls on or off

  always #5 clk = ~clk;

  modular_division_fermat DUT (.*);

  mdf_quotient_checker checker_i (.*);

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Receiver: random stalls, one long hold-off when asked.
  initial begin
    int gap;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      gap = stall_mode ? short_or_long_gap() : 0;
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1;
      @(negedge clk);
    end
  end

  // Drive one beat; lower valid only when the next beat is not back to back.
  task automatic send_beat(logic [29:0] dividend, logic [29:0] divisor, int gap);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {4'b0, divisor, dividend};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [29:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return 30'($urandom_range(0, 3));
      1:       return mdf_pkg::MODP - 30'($urandom_range(1, 3));
      2:       return 30'h3FFFFFFF - 30'($urandom_range(0, 3));  // above range
      3:       return mdf_pkg::MODP + 30'($urandom_range(0, 2));
      default: return 30'($urandom());
    endcase
  endfunction

  initial begin
    logic [29:0] edge_vals[8];
    edge_vals = '{30'd0, 30'd1, 30'd2, mdf_pkg::MODP - 30'd1, mdf_pkg::MODP,
                  mdf_pkg::MODP + 30'd1, 30'h3FFFFFFF, 30'h2AAAAAAA};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: zero divisor, zero dividend, extremes and above-range operands.
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        send_beat(edge_vals[(i * 3) % 8], edge_vals[(j * 5 + i) % 8], 0);
    send_beat(30'h15555555, 30'h15555555, 1);

    // Long receiver hold-off while the sender keeps offering beats.
    hold_off = 1;
    for (int n = 0; n < 200; n++) send_beat(rand_operand(), rand_operand(), 0);

    // Sender pauses until every result has drained.
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM - 200; n++) begin
      stall_mode = (n / 80) % 2 == 0;
      send_beat(rand_operand(), rand_operand(), (n / 60) % 3 == 1 ? 0 : short_or_long_gap());
    end
    s_axis_tvalid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/mdf_pkg.sv
src/mdf_mulmod.sv
src/modular_division_fermat.sv
dv/mdf_quotient_checker.sv
dv/tb_modular_division_fermat.sv
